/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL. Both expect i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tbpf_pkg.sv */
package tbpf_pkg;

    // Input beat field widths
    localparam int ACTION_W = 2;
    localparam int ADDR_W   = 14;
    localparam int WDATA_W  = 8;
    localparam int PIX_W    = 10;
    localparam int COLOR_W  = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int MAP_DIM_W   = 7;
    localparam int LOG2_W      = 3;
    localparam int SCROLL_W    = 17;

    localparam logic [LOG2_W-1:0] TILE_LOG2_MIN = 3'd3;
    localparam logic [LOG2_W-1:0] TILE_LOG2_MAX = 3'd5;
    localparam logic [LOG2_W-1:0] TILE_LOG2_RST = 3'd3;

    // Result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CNT_W = 4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_MAP_WR = 2'd0,
        ACT_PAT_WR = 2'd1,
        ACT_RENDER = 2'd2
    } t_action;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MAP_W    = 3'd0,
        CFG_MAP_H    = 3'd1,
        CFG_TILE_WL2 = 3'd2,
        CFG_TILE_HL2 = 3'd3,
        CFG_SCROLL_X = 3'd4,
        CFG_SCROLL_Y = 3'd5,
        CFG_TRANSP   = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               inside_map;
    } t_out_beat;

endpackage

/* rtl/tbpf_in_if.sv */
interface tbpf_in_if;
    logic                           valid;
    logic                           ready;
    logic [tbpf_pkg::ACTION_W-1:0]  action;
    logic [tbpf_pkg::ADDR_W-1:0]    address;
    logic [tbpf_pkg::WDATA_W-1:0]   write_data;
    logic [tbpf_pkg::PIX_W-1:0]     pixel_x;
    logic [tbpf_pkg::PIX_W-1:0]     pixel_y;

    modport source (
        output valid, action, address, write_data, pixel_x, pixel_y,
        input  ready
    );
    modport sink (
        input  valid, action, address, write_data, pixel_x, pixel_y,
        output ready
    );
endinterface

/* rtl/tbpf_out_if.sv */
interface tbpf_out_if;
    logic                           valid;
    logic                           ready;
    logic [tbpf_pkg::COLOR_W-1:0]   color;
    logic                           inside_map;

    modport source (
        output valid, color, inside_map,
        input  ready
    );
    modport sink (
        input  valid, color, inside_map,
        output ready
    );
endinterface

/* rtl/tilemap_background_pixel_fetch.sv */
// Scrolling tile-map background pixel fetch. Input beats either load the tile
// map store (action 0), load the pattern store (action 1) or render one screen
// pixel (action 2); only render beats produce an output beat, in input order.
// Throughput is one beat per clock while credits remain; a render result passes
// through the 6 pipeline stages and then the result queue. The rate is set by
// the two single-port stores: each is touched at one fixed stage, once per
// cycle, by whichever beat sits there, so writes and reads reach a store in
// input order and no forwarding is needed. An 8-entry result queue with credit
// counting lets input beats keep flowing while results wait to be taken; the
// input stalls only when 8 render results are outstanding. Stores are not
// cleared by reset; render beats must only touch entries already written.
// Configuration writes must happen while no beats are in flight.
//   S1: scrolled position sx, sy
//   S2: bounds check, tile coordinates and offsets within the tile
//   S3: map address row * width + column, map depth check
//   S4: tile map store access (read tile number or write entry)
//   S5: pattern address, pattern depth check
//   S6: pattern store access (read color or write pixel)
`include "assert_macros.svh"

module tilemap_background_pixel_fetch #(
    parameter int MAP_ENTRIES    = 4096,
    parameter int PATTERN_PIXELS = 16384,
    parameter int COLOR_BITS     = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tbpf_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [tbpf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    tbpf_in_if.sink                               i_in,
    tbpf_out_if.source                            o_out
);

    localparam int MAP_AW = $clog2(MAP_ENTRIES);
    localparam int PAT_AW = $clog2(PATTERN_PIXELS);
    localparam logic [tbpf_pkg::COLOR_W-1:0] COLOR_MASK =
        (COLOR_BITS >= tbpf_pkg::COLOR_W) ? {tbpf_pkg::COLOR_W{1'b1}}
                                          : tbpf_pkg::COLOR_W'((1 << COLOR_BITS) - 1);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [tbpf_pkg::MAP_DIM_W-1:0]   r_map_w;
    logic [tbpf_pkg::MAP_DIM_W-1:0]   r_map_h;
    logic [tbpf_pkg::LOG2_W-1:0]      r_tw_l2;
    logic [tbpf_pkg::LOG2_W-1:0]      r_th_l2;
    logic signed [tbpf_pkg::SCROLL_W-1:0] r_scroll_x;
    logic signed [tbpf_pkg::SCROLL_W-1:0] r_scroll_y;
    logic [tbpf_pkg::COLOR_W-1:0]     r_transp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_w    <= '0;
            r_map_h    <= '0;
            r_tw_l2    <= tbpf_pkg::TILE_LOG2_RST;
            r_th_l2    <= tbpf_pkg::TILE_LOG2_RST;
            r_scroll_x <= '0;
            r_scroll_y <= '0;
            r_transp   <= '0;
        end else if (i_cfg_we) begin
            case (tbpf_pkg::t_cfg_index'(i_cfg_index))
                tbpf_pkg::CFG_MAP_W:    r_map_w    <= i_cfg_data[tbpf_pkg::MAP_DIM_W-1:0];
                tbpf_pkg::CFG_MAP_H:    r_map_h    <= i_cfg_data[tbpf_pkg::MAP_DIM_W-1:0];
                tbpf_pkg::CFG_TILE_WL2: r_tw_l2    <= i_cfg_data[tbpf_pkg::LOG2_W-1:0];
                tbpf_pkg::CFG_TILE_HL2: r_th_l2    <= i_cfg_data[tbpf_pkg::LOG2_W-1:0];
                tbpf_pkg::CFG_SCROLL_X: r_scroll_x <= $signed(i_cfg_data[tbpf_pkg::SCROLL_W-1:0]);
                tbpf_pkg::CFG_SCROLL_Y: r_scroll_y <= $signed(i_cfg_data[tbpf_pkg::SCROLL_W-1:0]);
                tbpf_pkg::CFG_TRANSP:   r_transp   <= i_cfg_data[tbpf_pkg::COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Input handshake and credits
    // ---------------------------------------------------------------------
    logic [tbpf_pkg::FIFO_CNT_W-1:0] r_credit;
    logic [tbpf_pkg::FIFO_CNT_W-1:0] n_credit;
    logic w_accept;
    logic w_acc_render;
    logic w_push;
    logic w_pop;

    assign i_in.ready   = (r_credit != tbpf_pkg::FIFO_CNT_W'(tbpf_pkg::FIFO_DEPTH));
    assign w_accept     = i_in.valid && i_in.ready;
    assign w_acc_render = w_accept &&
                          (tbpf_pkg::t_action'(i_in.action) == tbpf_pkg::ACT_RENDER);

    always_comb begin
        n_credit = r_credit;
        if (w_acc_render && !w_pop) begin
            n_credit = r_credit + 1'b1;
        end else if (!w_acc_render && w_pop) begin
            n_credit = r_credit - 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline registers
    // ---------------------------------------------------------------------
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    tbpf_pkg::t_action r1_act, r2_act, r3_act, r4_act, r5_act, r6_act;
    logic [tbpf_pkg::ADDR_W-1:0]  r1_addr, r2_addr, r3_addr, r4_addr, r5_addr;
    logic [tbpf_pkg::WDATA_W-1:0] r1_wdata, r2_wdata, r3_wdata, r4_wdata, r5_wdata;

    logic signed [17:0] r1_sx, r1_sy, n1_sx, n1_sy;

    logic       r2_inside, n2_inside;
    logic [6:0] r2_tx, r2_ty, n2_tx, n2_ty;
    logic [4:0] r2_ix, r2_iy, n2_ix, n2_iy;

    logic        r3_inside, n3_inside;
    logic [13:0] r3_maddr, n3_maddr;
    logic [4:0]  r3_ix, r3_iy;

    logic       r4_inside;
    logic [4:0] r4_ix, r4_iy;
    logic [7:0] r4_tile;

    logic        r5_inside, n5_inside;
    logic [17:0] r5_paddr, n5_paddr;

    logic                         r6_inside;
    logic [tbpf_pkg::COLOR_W-1:0] r6_color;

    // S1: scroll add
    always_comb begin
        n1_sx = $signed({8'd0, i_in.pixel_x}) + $signed({r_scroll_x[16], r_scroll_x});
        n1_sy = $signed({8'd0, i_in.pixel_y}) + $signed({r_scroll_y[16], r_scroll_y});
    end

    // S2: bounds and tile split
    logic [11:0] w_vw, w_vh;
    logic [16:0] w_tx_full, w_ty_full;
    logic [4:0]  w_xmask, w_ymask;
    logic        w_size_ok;

    always_comb begin
        w_size_ok = (r_tw_l2 inside {[tbpf_pkg::TILE_LOG2_MIN:tbpf_pkg::TILE_LOG2_MAX]}) &&
                    (r_th_l2 inside {[tbpf_pkg::TILE_LOG2_MIN:tbpf_pkg::TILE_LOG2_MAX]}) &&
                    (r_map_w != '0) && (r_map_h != '0);
        w_vw      = 12'(r_map_w) << r_tw_l2;
        w_vh      = 12'(r_map_h) << r_th_l2;
        w_tx_full = r1_sx[16:0] >> r_tw_l2;
        w_ty_full = r1_sy[16:0] >> r_th_l2;
        w_xmask   = 5'h1F >> (3'd5 - r_tw_l2);
        w_ymask   = 5'h1F >> (3'd5 - r_th_l2);
        n2_inside = w_size_ok && !r1_sx[17] && !r1_sy[17] &&
                    (r1_sx[16:0] < 17'(w_vw)) && (r1_sy[16:0] < 17'(w_vh));
        n2_tx     = w_tx_full[6:0];
        n2_ty     = w_ty_full[6:0];
        n2_ix     = r1_sx[4:0] & w_xmask;
        n2_iy     = r1_sy[4:0] & w_ymask;
    end

    // S3: map address; at most 127 * 127 + 127, fits 14 bits
    always_comb begin
        n3_maddr  = 14'({7'd0, r2_ty} * {7'd0, r_map_w}) + 14'(r2_tx);
        n3_inside = r2_inside && (32'(n3_maddr) < 32'(MAP_ENTRIES));
    end

    // S5: pattern address; at most 255 * 1024 + 1023, fits 18 bits
    always_comb begin
        n5_paddr  = (18'(r4_tile) << ({1'b0, r_tw_l2} + {1'b0, r_th_l2})) +
                    (18'(r4_iy) << r_tw_l2) + 18'(r4_ix);
        n5_inside = r4_inside && (32'(n5_paddr) < 32'(PATTERN_PIXELS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r2_vld   <= 1'b0;
            r3_vld   <= 1'b0;
            r4_vld   <= 1'b0;
            r5_vld   <= 1'b0;
            r6_vld   <= 1'b0;
            r_credit <= '0;
        end else begin
            r1_vld   <= w_accept;
            r2_vld   <= r1_vld;
            r3_vld   <= r2_vld;
            r4_vld   <= r3_vld;
            r5_vld   <= r4_vld;
            r6_vld   <= r5_vld;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_act    <= tbpf_pkg::t_action'(i_in.action);
        r1_addr   <= i_in.address;
        r1_wdata  <= i_in.write_data;
        r1_sx     <= n1_sx;
        r1_sy     <= n1_sy;

        r2_act    <= r1_act;
        r2_addr   <= r1_addr;
        r2_wdata  <= r1_wdata;
        r2_inside <= n2_inside;
        r2_tx     <= n2_tx;
        r2_ty     <= n2_ty;
        r2_ix     <= n2_ix;
        r2_iy     <= n2_iy;

        r3_act    <= r2_act;
        r3_addr   <= r2_addr;
        r3_wdata  <= r2_wdata;
        r3_inside <= n3_inside;
        r3_maddr  <= n3_maddr;
        r3_ix     <= r2_ix;
        r3_iy     <= r2_iy;

        r4_act    <= r3_act;
        r4_addr   <= r3_addr;
        r4_wdata  <= r3_wdata;
        r4_inside <= r3_inside;
        r4_ix     <= r3_ix;
        r4_iy     <= r3_iy;

        r5_act    <= r4_act;
        r5_addr   <= r4_addr;
        r5_wdata  <= r4_wdata;
        r5_inside <= n5_inside;
        r5_paddr  <= n5_paddr;

        r6_act    <= r5_act;
        r6_inside <= r5_inside;
    end

    // ---------------------------------------------------------------------
    // Tile map store: single port, accessed at S4 by the beat registered out of S3
    // ---------------------------------------------------------------------
    logic [7:0]        m_map [MAP_ENTRIES];
    logic [31:0]       w_map_waddr_ext;
    logic [31:0]       w_map_raddr_ext;
    logic              w_map_we;
    logic [MAP_AW-1:0] w_map_idx;

    always_comb begin
        w_map_waddr_ext = 32'(r3_addr);
        w_map_raddr_ext = 32'(r3_maddr);
        w_map_we  = r3_vld && (r3_act == tbpf_pkg::ACT_MAP_WR) &&
                    (w_map_waddr_ext < 32'(MAP_ENTRIES));
        w_map_idx = w_map_we ? w_map_waddr_ext[MAP_AW-1:0] : w_map_raddr_ext[MAP_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) begin
            m_map[w_map_idx] <= r3_wdata;
        end
        r4_tile <= m_map[w_map_idx];
    end

    // ---------------------------------------------------------------------
    // Pattern store: single port, accessed at S6 by the beat registered out of S5
    // ---------------------------------------------------------------------
    logic [7:0]        m_pat [PATTERN_PIXELS];
    logic [31:0]       w_pat_waddr_ext;
    logic [31:0]       w_pat_raddr_ext;
    logic              w_pat_we;
    logic [PAT_AW-1:0] w_pat_idx;

    always_comb begin
        w_pat_waddr_ext = 32'(r5_addr);
        w_pat_raddr_ext = 32'(r5_paddr);
        w_pat_we  = r5_vld && (r5_act == tbpf_pkg::ACT_PAT_WR) &&
                    (w_pat_waddr_ext < 32'(PATTERN_PIXELS));
        w_pat_idx = w_pat_we ? w_pat_waddr_ext[PAT_AW-1:0] : w_pat_raddr_ext[PAT_AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_pat_we) begin
            m_pat[w_pat_idx] <= r5_wdata;
        end
        r6_color <= m_pat[w_pat_idx];
    end

    // ---------------------------------------------------------------------
    // Result queue; credits guarantee it never overflows
    // ---------------------------------------------------------------------
    tbpf_pkg::t_out_beat                r_fifo [tbpf_pkg::FIFO_DEPTH];
    logic [tbpf_pkg::FIFO_AW-1:0]       r_wr_ptr, r_rd_ptr;
    logic [tbpf_pkg::FIFO_CNT_W-1:0]    r_count;
    tbpf_pkg::t_out_beat                w_beat;
    tbpf_pkg::t_out_beat                w_head;

    always_comb begin
        w_push = r6_vld && (r6_act == tbpf_pkg::ACT_RENDER);
        w_beat.inside_map = r6_inside;
        w_beat.color      = (r6_inside ? r6_color : r_transp) & COLOR_MASK;
    end

    assign w_head           = r_fifo[r_rd_ptr];
    assign o_out.valid      = (r_count != '0);
    assign o_out.color      = w_head.color;
    assign o_out.inside_map = w_head.inside_map;
    assign w_pop            = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_push && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_beat;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `ASSERT_RST(a_credit_bound, r_credit <= tbpf_pkg::FIFO_CNT_W'(tbpf_pkg::FIFO_DEPTH), "credit above queue depth")
    `ASSERT_RST(a_queue_in_credit, r_count <= r_credit, "queued results exceed credits")
    `ASSERT_RST(a_no_overflow, !(w_push && r_count == tbpf_pkg::FIFO_CNT_W'(tbpf_pkg::FIFO_DEPTH)), "push into full result queue")
    `ASSERT_RST(a_render_latency, w_acc_render |-> ##6 w_push, "render beat did not reach result queue")
    `ASSERT_IMPL(a_credit_step, w_acc_render && !w_pop, r_credit == $past(r_credit) + 1'b1, "credit did not count render")

endmodule
